// ----- rtl/core/fca_pkg.sv -----
// fca_pkg: shared types, constants and helpers for the cluster allocator.
// Used by every module under rtl/core; no dependencies.
`timescale 1ns / 1ps

package fca_pkg;

   localparam int CLUSTERS   = 4096;
   localparam int IDX_W      = $clog2(CLUSTERS);
   localparam int CMD_W      = 3;
   localparam int CLUSTER_W  = 12;
   localparam int WORD_W     = 32;
   localparam int REQ_DATA_W = ((CLUSTER_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((WORD_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 3'd0,
      CMD_ALLOC  = 3'd1,
      CMD_FREE   = 3'd2,
      CMD_LOAD   = 3'd3,
      CMD_HEAD   = 3'd4
   } fca_op_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // transaction accepted this cycle
      logic finish;    // second step: read data used, result pushed
   } fca_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;  // output register can take a result this cycle
   } fca_stat_type;

   function automatic logic in_range(input logic [WORD_W-1:0] v);
      return v < WORD_W'(CLUSTERS);
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [WORD_W-1:0] v);
      return v[IDX_W-1:0];
   endfunction

endpackage

// ----- rtl/core/fca_ctrl.sv -----
// fca_ctrl: two-step sequencer for the cluster allocator.
// Depends on fca_pkg for the command and status structs.
`timescale 1ns / 1ps

module fca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fca_pkg::fca_stat_type stat,
   output fca_pkg::fca_cmd_type  cmd
);
   import fca_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_tready  = ready_ff;
   assign cmd.capture = req_tvalid && ready_ff;
   assign cmd.finish  = (state_ff == ST_FINISH) && stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff <= ST_FINISH;
                  ready_ff <= 1'b0;
               end
            end
            ST_FINISH: begin
               // hold here while the output register is still occupied
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/fca_datapath.sv -----
// fca_datapath: link table memory, free-list head and result register.
// Depends on fca_pkg; sequenced by fca_ctrl through fca_cmd_type.
`timescale 1ns / 1ps

module fca_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fca_pkg::fca_cmd_type                 cmd,
   output fca_pkg::fca_stat_type                stat,
   input  logic [fca_pkg::CMD_W-1:0]            req_op,
   input  logic [fca_pkg::CLUSTER_W-1:0]        req_cluster,
   input  logic [fca_pkg::WORD_W-1:0]           req_value,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fca_pkg::WORD_W-1:0]           rsp_value,
   output logic                                 rsp_status
);
   import fca_pkg::*;

   logic [WORD_W-1:0] link_mem [CLUSTERS];

   logic [CMD_W-1:0]  op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              cl_ok_ff;
   logic              alloc_ok_ff;
   logic [WORD_W-1:0] rdata_ff;
   logic [WORD_W-1:0] head_ff, head_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_status_ff, rsp_status_in;

   logic [WORD_W-1:0] req_cl_word;
   logic              req_cl_ok;
   logic              head_ok;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              fin_alloc;

   assign req_cl_word = WORD_W'(req_cluster);
   assign req_cl_ok   = in_range(req_cl_word);
   assign head_ok     = (head_ff != '0) && in_range(head_ff);
   assign rd_addr     = (req_op == CMD_LOOKUP) ? to_idx(req_cl_word) : to_idx(head_ff);
   assign fin_alloc   = cmd.finish && (op_ff == CMD_ALLOC) && alloc_ok_ff;

   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // one write port: free/load at capture, allocate link at finish
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = to_idx(req_cl_word);
      wr_data = req_value;
      head_in = head_ff;
      if (cmd.capture) begin
         case (req_op)
            CMD_FREE: begin
               if (req_cl_ok) begin
                  wr_en   = 1'b1;
                  wr_data = head_ff;
                  head_in = req_cl_word;
               end
            end
            CMD_LOAD: begin
               wr_en = req_cl_ok;
            end
            CMD_HEAD: begin
               head_in = req_value;
            end
            default: ;
         endcase
      end else if (fin_alloc) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = head_ff;
         head_in = rdata_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = 1'b0;
         case (op_ff)
            CMD_LOOKUP: begin
               if (cl_ok_ff) rsp_value_in = rdata_ff;
            end
            CMD_ALLOC: begin
               if (alloc_ok_ff) rsp_value_in = head_ff;
               rsp_status_in = cl_ok_ff && !alloc_ok_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) rdata_ff <= link_mem[rd_addr];
      if (wr_en) link_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_op;
         idx_ff      <= to_idx(req_cl_word);
         cl_ok_ff    <= req_cl_ok;
         alloc_ok_ff <= req_cl_ok && head_ok;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- rtl/core/fat_chain_free_list_allocator_core.sv -----
// Top level of the FAT-style cluster allocator: stream ports, sequencer and datapath.
// Depends on fca_pkg, fca_ctrl and fca_datapath.
//
//   channel | dir | tdata (low bit first)                  | tuser
//   req     | in  | cluster[11:0], entry_value[43:12], pad | cmd[2:0]
//   rsp     | out | result_value[31:0]                     | status[0]
//
// Each transaction goes through accept (table read issued), then finish
// (read data used, allocate link written, result registered). The registered
// table read sets this: allocate reads the head's link, then writes.
// Synchronous reset empties the free list; the link table is not cleared.
// A stalled rsp holds the sequencer in finish; req stays low until it moves.
`timescale 1ns / 1ps

module fat_chain_free_list_allocator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cluster, entry_value, zero pad
   input  logic [fca_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic [fca_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_value
   output logic [fca_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic                               rsp_tuser
);
   import fca_pkg::*;

   fca_cmd_type       cmd;
   fca_stat_type      stat;
   logic [WORD_W-1:0] rsp_value;

   fca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fca_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_op      (req_tuser),
      .req_cluster (req_tdata[CLUSTER_W-1:0]),
      .req_value   (req_tdata[CLUSTER_W+WORD_W-1:CLUSTER_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_value);

endmodule

// ----- rtl/core/fca_checker.sv -----
// fca_checker: port-level assertions for the cluster allocator top level.
// Depends on fca_pkg; bound to fat_chain_free_list_allocator_core below.
`timescale 1ns / 1ps

module fca_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             rsp_tuser
);
   import fca_pkg::*;

   // one transaction in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after an accepted transaction");

   // a no-space status never comes with a cluster number
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("failed allocate returned a nonzero value");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind fat_chain_free_list_allocator_core fca_checker u_fca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
